// File: rtl/core/srfc_pkg.sv
// Shared types and constants for the sync-run frame capture block.
package srfc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RunW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [RunW-1:0] RunMax = 4'd15;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegSyncValue   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSyncLength  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameLength = 2'd2;

  // Reset values of the registers
  localparam logic [ByteW-1:0] SyncValueRst   = 8'hFE;
  localparam logic [RunW-1:0]  SyncLengthRst  = 4'd5;
  localparam logic [ByteW-1:0] FrameLengthRst = 8'd40;

  typedef struct packed {
    logic [ByteW-1:0] sync_value;
    logic [RunW-1:0]  sync_length;
    logic [ByteW-1:0] frame_length;
  } srfc_cfg_t;

  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] byte_index;
    logic             frame_last;
  } srfc_res_t;

endpackage

// File: rtl/core/srfc_cfg.sv
// Configuration register file for the sync-run frame capture block.
module srfc_cfg
  import srfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output srfc_cfg_t           cfg
);

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value   <= SyncValueRst;
      cfg.sync_length  <= SyncLengthRst;
      cfg.frame_length <= FrameLengthRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSyncValue:   cfg.sync_value   <= cfg_wdata;
        RegSyncLength:  cfg.sync_length  <= cfg_wdata[RunW-1:0];
        RegFrameLength: cfg.frame_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/srfc_track.sv
// Sync run counter and frame position tracking, one byte per transaction.
module srfc_track
  import srfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [ByteW-1:0] rx_byte,
  input  srfc_cfg_t        cfg,
  output srfc_res_t        res
);

  logic [RunW-1:0]  match_run, match_run_next;
  logic             in_frame, in_frame_next;
  logic [ByteW-1:0] write_position, write_position_next;
  logic [ByteW-1:0] pos_inc;
  logic             last;

  // Update the run count, then decide start, emit or frame end
  always_comb begin
    if (rx_byte == cfg.sync_value) begin
      match_run_next = (match_run == RunMax) ? match_run : match_run + 1'b1;
    end else begin
      match_run_next = '0;
    end

    pos_inc             = write_position + 1'b1;
    last                = (pos_inc == cfg.frame_length);
    in_frame_next       = in_frame;
    write_position_next = write_position;

    if (!in_frame) begin
      if (match_run_next >= cfg.sync_length) begin
        in_frame_next       = 1'b1;
        write_position_next = '0;
      end
    end else if (last) begin
      in_frame_next       = 1'b0;
      write_position_next = '0;
    end else begin
      write_position_next = pos_inc;
    end

    res.emit         = in_frame;
    res.payload_byte = rx_byte;
    res.byte_index   = write_position;
    res.frame_last   = last;
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      match_run      <= '0;
      in_frame       <= 1'b0;
      write_position <= '0;
    end else if (accept) begin
      match_run      <= match_run_next;
      in_frame       <= in_frame_next;
      write_position <= write_position_next;
    end
  end

endmodule

// File: rtl/core/srfc_out.sv
// Result register with valid/stall handshake toward the consumer.
module srfc_out
  import srfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  srfc_res_t        res,
  output logic             busy,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [ByteW-1:0] payload_byte,
  output logic [ByteW-1:0] byte_index,
  output logic             frame_last
);

  logic load;

  // Load when the register is empty or its transaction completes this cycle
  assign busy = res_valid && res_stall;
  assign load = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= accept && res.emit;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (load && accept && res.emit) begin
      payload_byte <= res.payload_byte;
      byte_index   <= res.byte_index;
      frame_last   <= res.frame_last;
    end
  end

endmodule

// File: rtl/core/sync_run_frame_capture.sv
// Top level: preamble-synchronized fixed-length byte deframer.
// A payload byte appears on the result port in the cycle after it is accepted.
// Throughput: one byte per cycle; input stalls only while a result is held stalled.
// The single result register and the run/position update on each accepted byte set that rate.
// Reset (rst, synchronous) clears the run count and position, leaves the frame
// state idle, and loads sync value 0xFE, sync length 5 and frame length 40.
module sync_run_frame_capture
  import srfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  logic [ByteW-1:0]    rx_byte,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [ByteW-1:0]    payload_byte,
  output logic [ByteW-1:0]    byte_index,
  output logic                frame_last
);

  srfc_cfg_t cfg;
  srfc_res_t res;
  logic      busy;
  logic      accept;

  // Take a byte whenever the result register can take its result
  assign rx_stall = busy;
  assign accept   = rx_valid && !busy;

  srfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srfc_track u_track (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  srfc_out u_out (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .res          (res),
    .busy         (busy),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_last   (frame_last)
  );

endmodule
